FILE: hw/rtl/adam_pkg.sv
// Shared types, constants and arithmetic step functions for the Adam update block.
// No dependencies; used by adam_optimizer_update and adam_chk.
package adam_pkg;

  localparam int NUM_ELEMENTS_DEF = 4096;
  localparam int VALUE_BITS_DEF   = 32;

  localparam int IDX_W      = 12;
  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DECAY   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DECAY  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON       = 4'd3;

  localparam logic [23:0] LR_RST    = 24'd16777;
  localparam logic [15:0] BETA1_RST = 16'd58982;
  localparam logic [15:0] BETA2_RST = 16'd65470;
  localparam logic [15:0] EPS_RST   = 16'd1;
  localparam logic [31:0] POWER_RST = 32'hFFFF_FFFF;

  localparam int A_STEPS = 48;
  localparam int B_STEPS = 32;
  localparam int C_STEPS = 40;

  typedef struct packed {
    logic                     new_step;
    logic [IDX_W-1:0]         elem_index;
    logic signed [DATA_W-1:0] gradient;
    logic signed [DATA_W-1:0] param_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_index;
    logic signed [DATA_W-1:0] new_value;
    logic                     saturated;
  } out_item_t;

  typedef struct packed {
    logic [32:0] rem;
    logic        q;
  } div_res_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_res_t;

  // one restoring division step
  function automatic div_res_t div_step(input logic [32:0] rem, input logic nb,
                                        input logic [32:0] d);
    logic [33:0] t;
    div_res_t    r;
    t = {rem, nb};
    if (t >= {1'b0, d}) begin
      r.rem = 33'(t - {1'b0, d});
      r.q   = 1'b1;
    end else begin
      r.rem = t[32:0];
      r.q   = 1'b0;
    end
    return r;
  endfunction

  // one digit of the integer square root
  function automatic sqrt_res_t sqrt_step(input logic [33:0] rem, input logic [31:0] root,
                                          input logic [1:0] dig);
    logic [35:0] t;
    logic [35:0] trial;
    sqrt_res_t   r;
    t     = {rem, dig};
    trial = {2'b00, root, 2'b01};
    if (t >= trial) begin
      r.rem  = 34'(t - trial);
      r.root = {root[30:0], 1'b1};
    end else begin
      r.rem  = t[33:0];
      r.root = {root[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/adam_optimizer_update.sv
// Adam update block: per-element moment RAM, bias-corrected step, pipelined dividers and root.
// Depends on adam_pkg and adam_ram.
//
// Usage:
//   Input transactions (in_valid/in_stall, in_data) carry one element: index, gradient,
//   current value and the new_step flag that advances the beta powers first.
//   Each accepted transaction yields exactly one result on out_valid/out_stall/out_data,
//   in order. Throughput is one transaction per cycle while in_stall is low, set by the
//   fully pipelined datapath (48-step moment dividers, 32-step root, 40-step step
//   divider).
//   Moments live in one RAM, read at acceptance and written back from stage 1; a
//   back-to-back transaction on the same index takes the value just written.
//   Results go through a two-entry output buffer; while it is full, in_stall is raised
//   and the whole pipeline holds.
//   After reset the moment RAM is cleared, one entry per cycle, all NUM_ELEMENTS entries;
//   in_stall stays high during that pass. Configuration (cfg_valid/cfg_ready, always
//   ready) may be written at any time but takes effect on items in flight.
module adam_optimizer_update #(
  parameter int NUM_ELEMENTS = adam_pkg::NUM_ELEMENTS_DEF,
  parameter int VALUE_BITS   = adam_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  adam_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output adam_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [adam_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [adam_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int ADDR_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(NUM_ELEMENTS - 1);
  localparam int AS = adam_pkg::A_STEPS;
  localparam int BS = adam_pkg::B_STEPS;
  localparam int CS = adam_pkg::C_STEPS;
  localparam logic signed [65:0] V_HI = (66'sd1 <<< (VALUE_BITS - 1)) - 66'sd1;
  localparam logic signed [65:0] V_LO = -V_HI - 66'sd1;

  typedef struct packed {
    logic [11:0]        idx;
    logic signed [31:0] p;
    logic               mneg;
    logic               sat;
    logic               m_ovf;
    logic               v_ovf;
    logic [32:0]        m_rem;
    logic [47:0]        m_num;
    logic [32:0]        v_rem;
    logic [47:0]        v_num;
    logic [32:0]        c1;
    logic [32:0]        c2;
  } a_t;

  typedef struct packed {
    logic [11:0]        idx;
    logic signed [31:0] p;
    logic               mneg;
    logic               sat;
    logic [46:0]        mh;
    logic [63:0]        x;
    logic [33:0]        rem;
    logic [31:0]        root;
  } b_t;

  typedef struct packed {
    logic [11:0]        idx;
    logic signed [31:0] p;
    logic               mneg;
    logic               sat;
    logic               ovf;
    logic [32:0]        rem;
    logic [39:0]        num;
    logic [32:0]        den;
  } c_t;

  // configuration and bias powers
  logic [23:0] lr_r;
  logic [15:0] b1_r, b2_r, eps_r;
  logic [31:0] pw1_r, pw2_r, pw1_nxt, pw2_nxt;
  logic [47:0] pw1_prod, pw2_prod;

  // control
  logic              en, acc;
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [1:0]        ob_cnt_r;
  adam_pkg::out_item_t ob_r [2];
  adam_pkg::out_item_t f_item;
  logic              push, pop;

  // stage 1 (RAM data available)
  logic               s1_v_r, s1_inr_r, s1_gsat_r;
  logic [11:0]        s1_idx_r;
  logic signed [31:0] s1_g_r, s1_p_r;
  logic [31:0]        s1_gsq_r, s1_pw1_r, s1_pw2_r;
  logic [31:0]        ga;
  logic [63:0]        gprod;

  logic [63:0]        rd_data;
  logic               fwd_v_r;
  logic [11:0]        fwd_idx_r;
  logic [63:0]        fwd_r;
  logic signed [31:0] m0;
  logic [31:0]        v0;
  logic [16:0]        b1c, b2c;
  logic signed [50:0] m_sum;
  logic signed [34:0] m_sh;
  logic [49:0]        v_sum;
  logic [33:0]        v_sh;
  logic               m_ovf1, v_ovf1;
  logic signed [31:0] m_new;
  logic [31:0]        v_new;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [63:0]        ram_wdata;

  // stage 2
  logic               s2_v_r, s2_sat_r;
  logic [11:0]        s2_idx_r;
  logic signed [31:0] s2_p_r, s2_m_r;
  logic [31:0]        s2_v_val_r, s2_pw1_r, s2_pw2_r;
  logic [31:0]        mag;

  a_t a_init;
  a_t a_r [AS+1];
  a_t a_nxt [AS];
  logic [AS:0] a_v_r;

  b_t b_init;
  b_t b_r [BS+1];
  b_t b_nxt [BS];
  logic [BS:0] b_v_r;

  c_t c_init;
  c_t c_r [CS+1];
  c_t c_nxt [CS];
  logic [CS:0] c_v_r;

  logic               pr_v_r, pr_mneg_r, pr_sat_r;
  logic [11:0]        pr_idx_r;
  logic signed [31:0] pr_p_r;
  logic [62:0]        pr_prod_r;
  logic [38:0]        qc;
  logic               q_clamp;
  logic [38:0]        delta;
  logic signed [40:0] nv;
  logic signed [65:0] nv_w;
  logic signed [65:0] nv_c;
  logic               nv_sat;

  assign en        = (ob_cnt_r != 2'd2);
  assign in_stall  = !en || clr_busy_r;
  assign acc       = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r  <= adam_pkg::LR_RST;
      b1_r  <= adam_pkg::BETA1_RST;
      b2_r  <= adam_pkg::BETA2_RST;
      eps_r <= adam_pkg::EPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        adam_pkg::CFG_LEARNING_RATE: lr_r  <= cfg_data;
        adam_pkg::CFG_FIRST_DECAY:   b1_r  <= cfg_data[15:0];
        adam_pkg::CFG_SECOND_DECAY:  b2_r  <= cfg_data[15:0];
        adam_pkg::CFG_EPSILON:       eps_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // bias powers
  assign pw1_prod = pw1_r * b1_r;
  assign pw2_prod = pw2_r * b2_r;
  assign pw1_nxt  = (acc && in_data.new_step) ? pw1_prod[47:16] : pw1_r;
  assign pw2_nxt  = (acc && in_data.new_step) ? pw2_prod[47:16] : pw2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw1_r <= adam_pkg::POWER_RST;
      pw2_r <= adam_pkg::POWER_RST;
    end else begin
      pw1_r <= pw1_nxt;
      pw2_r <= pw2_nxt;
    end
  end

  // clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == CLR_LAST) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // stage 0: squared gradient
  assign ga    = in_data.gradient[31] ? 32'(-in_data.gradient) : 32'(in_data.gradient);
  assign gprod = ga * ga;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_idx_r  <= in_data.elem_index;
      s1_inr_r  <= (32'(in_data.elem_index) < 32'(NUM_ELEMENTS));
      s1_g_r    <= in_data.gradient;
      s1_p_r    <= in_data.param_value;
      s1_gsat_r <= |gprod[63:48];
      s1_gsq_r  <= (|gprod[63:48]) ? 32'hFFFF_FFFF : gprod[47:16];
      s1_pw1_r  <= pw1_nxt;
      s1_pw2_r  <= pw2_nxt;
    end
  end

  adam_ram #(
    .WIDTH(64),
    .DEPTH(NUM_ELEMENTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (en),
    .raddr(ADDR_W'(in_data.elem_index)),
    .rdata(rd_data)
  );

  // stage 1: moment update
  always_comb begin
    if (!s1_inr_r) begin
      m0 = '0;
      v0 = '0;
    end else if (fwd_v_r && (fwd_idx_r == s1_idx_r)) begin
      m0 = fwd_r[63:32];
      v0 = fwd_r[31:0];
    end else begin
      m0 = rd_data[63:32];
      v0 = rd_data[31:0];
    end
    b1c    = 17'(17'h1_0000 - {1'b0, b1_r});
    b2c    = 17'(17'h1_0000 - {1'b0, b2_r});
    m_sum  = $signed({1'b0, b1_r}) * m0 + $signed({1'b0, b1c}) * s1_g_r;
    m_sh   = m_sum[50:16];
    m_ovf1 = (m_sh[34:31] != {4{m_sh[34]}});
    m_new  = m_ovf1 ? (m_sh[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : m_sh[31:0];
    v_sum  = b2_r * v0 + b2c * s1_gsq_r;
    v_sh   = v_sum[49:16];
    v_ovf1 = |v_sh[33:32];
    v_new  = v_ovf1 ? 32'hFFFF_FFFF : v_sh[31:0];
  end

  assign ram_we    = clr_busy_r || (en && s1_v_r && s1_inr_r);
  assign ram_waddr = clr_busy_r ? clr_cnt_r : ADDR_W'(s1_idx_r);
  assign ram_wdata = clr_busy_r ? 64'd0 : {m_new, v_new};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
      s2_v_r  <= 1'b0;
    end else if (en) begin
      fwd_v_r <= s1_v_r && s1_inr_r;
      s2_v_r  <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_idx_r  <= s1_idx_r;
      fwd_r      <= {m_new, v_new};
      s2_idx_r   <= s1_idx_r;
      s2_p_r     <= s1_p_r;
      s2_m_r     <= m_new;
      s2_v_val_r <= v_new;
      s2_sat_r   <= s1_gsat_r || m_ovf1 || v_ovf1;
      s2_pw1_r   <= s1_pw1_r;
      s2_pw2_r   <= s1_pw2_r;
    end
  end

  // stage 2: bias correction divider setup
  always_comb begin
    mag          = s2_m_r[31] ? 32'(-s2_m_r) : 32'(s2_m_r);
    a_init.idx   = s2_idx_r;
    a_init.p     = s2_p_r;
    a_init.mneg  = s2_m_r[31];
    a_init.sat   = s2_sat_r;
    a_init.c1    = 33'h1_0000_0000 - {1'b0, s2_pw1_r};
    a_init.c2    = 33'h1_0000_0000 - {1'b0, s2_pw2_r};
    a_init.m_rem = {17'd0, mag[31:16]};
    a_init.m_num = {mag[15:0], 32'd0};
    a_init.v_rem = {17'd0, s2_v_val_r[31:16]};
    a_init.v_num = {s2_v_val_r[15:0], 32'd0};
    a_init.m_ovf = ({17'd0, mag[31:16]} >= a_init.c1);
    a_init.v_ovf = ({17'd0, s2_v_val_r[31:16]} >= a_init.c2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= a_init;
    end
  end

  for (genvar k = 0; k < AS; k++) begin : g_a
    adam_pkg::div_res_t dm, dv;
    always_comb begin
      dm             = adam_pkg::div_step(a_r[k].m_rem, a_r[k].m_num[47], a_r[k].c1);
      dv             = adam_pkg::div_step(a_r[k].v_rem, a_r[k].v_num[47], a_r[k].c2);
      a_nxt[k]       = a_r[k];
      a_nxt[k].m_rem = dm.rem;
      a_nxt[k].m_num = {a_r[k].m_num[46:0], dm.q};
      a_nxt[k].v_rem = dv.rem;
      a_nxt[k].v_num = {a_r[k].v_num[46:0], dv.q};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        a_r[k+1] <= a_nxt[k];
      end
    end
  end

  // square root setup
  always_comb begin
    b_init.idx  = a_r[AS].idx;
    b_init.p    = a_r[AS].p;
    b_init.mneg = a_r[AS].mneg;
    b_init.sat  = a_r[AS].sat || a_r[AS].m_ovf || a_r[AS].m_num[47] || a_r[AS].v_ovf;
    b_init.mh   = (a_r[AS].m_ovf || a_r[AS].m_num[47]) ? {47{1'b1}} : a_r[AS].m_num[46:0];
    b_init.x    = {(a_r[AS].v_ovf ? {48{1'b1}} : a_r[AS].v_num), 16'd0};
    b_init.rem  = '0;
    b_init.root = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_r[0] <= b_init;
    end
  end

  for (genvar k = 0; k < BS; k++) begin : g_b
    adam_pkg::sqrt_res_t sr;
    always_comb begin
      sr            = adam_pkg::sqrt_step(b_r[k].rem, b_r[k].root, b_r[k].x[63:62]);
      b_nxt[k]      = b_r[k];
      b_nxt[k].rem  = sr.rem;
      b_nxt[k].root = sr.root;
      b_nxt[k].x    = {b_r[k].x[61:0], 2'b00};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        b_r[k+1] <= b_nxt[k];
      end
    end
  end

  // step divider setup
  always_comb begin
    c_init.idx  = b_r[BS].idx;
    c_init.p    = b_r[BS].p;
    c_init.mneg = b_r[BS].mneg;
    c_init.sat  = b_r[BS].sat;
    c_init.den  = 33'(b_r[BS].root) + 33'(eps_r);
    if (c_init.den == 33'd0) begin
      c_init.den = 33'd1;
    end
    c_init.rem = {10'd0, b_r[BS].mh[46:24]};
    c_init.num = {b_r[BS].mh[23:0], 16'd0};
    c_init.ovf = ({10'd0, b_r[BS].mh[46:24]} >= c_init.den);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r[0] <= c_init;
    end
  end

  for (genvar k = 0; k < CS; k++) begin : g_c
    adam_pkg::div_res_t dq;
    always_comb begin
      dq           = adam_pkg::div_step(c_r[k].rem, c_r[k].num[39], c_r[k].den);
      c_nxt[k]     = c_r[k];
      c_nxt[k].rem = dq.rem;
      c_nxt[k].num = {c_r[k].num[38:0], dq.q};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        c_r[k+1] <= c_nxt[k];
      end
    end
  end

  // learning rate product
  assign q_clamp = c_r[CS].ovf || c_r[CS].num[39];
  assign qc      = q_clamp ? {39{1'b1}} : c_r[CS].num[38:0];

  always_ff @(posedge clk) begin
    if (en) begin
      pr_idx_r  <= c_r[CS].idx;
      pr_p_r    <= c_r[CS].p;
      pr_mneg_r <= c_r[CS].mneg;
      pr_sat_r  <= c_r[CS].sat || q_clamp;
      pr_prod_r <= qc * lr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= '0;
      b_v_r  <= '0;
      c_v_r  <= '0;
      pr_v_r <= 1'b0;
    end else if (en) begin
      a_v_r  <= {a_v_r[AS-1:0], s2_v_r};
      b_v_r  <= {b_v_r[BS-1:0], a_v_r[AS]};
      c_v_r  <= {c_v_r[CS-1:0], b_v_r[BS]};
      pr_v_r <= c_v_r[CS];
    end
  end

  // final value and clamp
  always_comb begin
    delta  = pr_prod_r[62:24];
    nv     = pr_mneg_r ? (41'(pr_p_r) + $signed({2'b00, delta}))
                       : (41'(pr_p_r) - $signed({2'b00, delta}));
    nv_w   = 66'(nv);
    nv_sat = 1'b0;
    nv_c   = nv_w;
    if (nv_w > V_HI) begin
      nv_c   = V_HI;
      nv_sat = 1'b1;
    end else if (nv_w < V_LO) begin
      nv_c   = V_LO;
      nv_sat = 1'b1;
    end
    f_item.out_index = pr_idx_r;
    f_item.new_value = 32'(nv_c);
    f_item.saturated = pr_sat_r || nv_sat;
  end

  // output buffer
  assign push      = en && pr_v_r;
  assign pop       = out_valid && !out_stall;
  assign out_valid = (ob_cnt_r != 2'd0);
  assign out_data  = ob_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_cnt_r <= 2'd0;
    end else if (push && !pop) begin
      ob_cnt_r <= ob_cnt_r + 2'd1;
    end else if (pop && !push) begin
      ob_cnt_r <= ob_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (ob_cnt_r == 2'd1) begin
        ob_r[0] <= f_item;
      end else begin
        ob_r[0] <= ob_r[1];
        ob_r[1] <= f_item;
      end
    end else if (push) begin
      if (ob_cnt_r == 2'd0) begin
        ob_r[0] <= f_item;
      end else begin
        ob_r[1] <= f_item;
      end
    end else if (pop) begin
      ob_r[0] <= ob_r[1];
    end
  end

endmodule

FILE: hw/rtl/adam_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module adam_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/adam_chk.sv
// Port-level checker for adam_optimizer_update, attached with bind.
// Depends on adam_pkg.
module adam_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input adam_pkg::out_item_t out_data
);

  // a held result transaction stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // moment clear runs right after reset, so input is refused
  a_clr_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind adam_optimizer_update adam_chk u_chk (.*);
